### rtl/ssa_pkg.sv
package ssa_pkg;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 12;
  localparam int STATUS_W = 2;
  localparam int SEC_W    = 15;
  localparam int LIM_W    = 13;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 13;

  // Bitmap row geometry
  localparam int WORD_W = 64;
  localparam int BIT_W  = 6;

  localparam int QDEPTH = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SWAP_OUT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SWAP_IN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNDEF    = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NODEV = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_PRESENT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE   = 1'd1;

  localparam logic [LIM_W-1:0] SLOTS_IN_USE_RST = 13'd4096;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_SWAP_IN,
    OP_FREE,
    OP_ERROR
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_EMIT,
    S_SINGLE
  } bstate_e;

endpackage

### rtl/ssa_intf.sv
interface ssa_in_if;
  import ssa_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SLOT_W-1:0] slot_index;

  modport source (output valid, output cmd, output slot_index, input ready);
  modport sink   (input valid, input cmd, input slot_index, output ready);
endinterface

interface ssa_out_if;
  import ssa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_number;
  logic [SEC_W-1:0]    sector_address;
  logic                last;

  modport source (output valid, output status, output slot_number, output sector_address,
                  output last, input ready);
  modport sink   (input valid, input status, input slot_number, input sector_address,
                  input last, output ready);
endinterface

interface ssa_cfg_if;
  import ssa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/swap_slot_allocator_top.sv
// First-fit swap slot allocator. A bitmap of SLOTS bits, kept in a 64-bit wide
// RAM with a per-row valid bit and a per-row full flag, tracks used slots; all
// slots read as free right after reset with no clearing pass. Swap out takes
// the lowest free slot below the usable count and returns SECTORS_PER_SLOT
// results (slot * SECTORS_PER_SLOT + step, last on the final one); swap in
// checks and frees a slot and returns the same sector list; free returns one
// acknowledgement; errors return one result. Requests go through a two-entry
// queue to the bitmap sequencer, which reads the bitmap row, checks it and
// writes it back in a read-modify-write, then sends its results from the
// output register at one result per cycle while the output is not stalled. A
// no-device or range error, or a swap out while every row is flagged full,
// skips the row read and returns its single result directly.
// Configuration writes must be made while no request is in flight.
module swap_slot_allocator_top #(
  parameter int SLOTS            = 4096,
  parameter int SECTORS_PER_SLOT = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssa_in_if.sink     req_i,
  ssa_cfg_if.sink    cfg_i,
  ssa_out_if.source  rsp_o
);
  import ssa_pkg::*;

  op_t              f_op, q_op;
  logic             f_valid, f_ready;
  logic             q_valid, q_pop;
  logic [LIM_W-1:0] limit;

  ssa_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_i      (cfg_i),
    .op_o       (f_op),
    .op_valid_o (f_valid),
    .op_ready_i (f_ready),
    .limit_o    (limit)
  );

  ssa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_op),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_op)
  );

  ssa_back #(
    .SLOTS            (SLOTS),
    .SECTORS_PER_SLOT (SECTORS_PER_SLOT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (q_op),
    .op_valid_i (q_valid),
    .op_pop_o   (q_pop),
    .limit_i    (limit),
    .rsp_o      (rsp_o)
  );

endmodule

### rtl/ssa_ram.sv
module ssa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ssa_front.sv
module ssa_front #(
  parameter int SLOTS = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  ssa_in_if.sink                    req_i,
  ssa_cfg_if.sink                   cfg_i,
  output ssa_pkg::op_t              op_o,
  output logic                      op_valid_o,
  input  logic                      op_ready_i,
  output logic [ssa_pkg::LIM_W-1:0] limit_o
);
  import ssa_pkg::*;

  localparam int SLOT_CAP = (SLOTS > 8191) ? 8191 : SLOTS;
  localparam logic [LIM_W-1:0] CAP_C = LIM_W'(SLOT_CAP);

  logic             dev_q, dev_d;
  logic [LIM_W-1:0] slots_q, slots_d;
  logic [LIM_W-1:0] limit;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    dev_d   = dev_q;
    slots_d = slots_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_DEVICE_PRESENT: dev_d   = cfg_i.data[0];
        CFG_SLOTS_IN_USE:   slots_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q   <= 1'b1;
      slots_q <= SLOTS_IN_USE_RST;
    end else begin
      dev_q   <= dev_d;
      slots_q <= slots_d;
    end
  end

  // saturate the usable count at the bitmap size, capped at 8191
  assign limit   = (slots_q > CAP_C) ? CAP_C : slots_q;
  assign limit_o = limit;

  always_comb begin
    op_o.op     = OP_ERROR;
    op_o.slot   = req_i.slot_index;
    op_o.status = ST_OK;
    if (!dev_q) begin
      op_o.status = ST_NODEV;
      op_o.slot   = '0;
    end else begin
      case (req_i.cmd)
        CMD_SWAP_OUT: op_o.op = OP_ALLOC;
        CMD_SWAP_IN, CMD_FREE: begin
          if (LIM_W'(req_i.slot_index) >= limit) begin
            op_o.status = ST_BAD;
            op_o.slot   = '0;
          end else begin
            op_o.op = (req_i.cmd == CMD_SWAP_IN) ? OP_SWAP_IN : OP_FREE;
          end
        end
        default: ;
      endcase
    end
  end

  // undefined commands transfer in but are dropped here
  assign req_i.ready = op_ready_i;
  assign op_valid_o  = req_i.valid && (req_i.cmd != CMD_UNDEF);

endmodule

### rtl/ssa_queue.sv
module ssa_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  ssa_pkg::op_t push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_i,
  output ssa_pkg::op_t pop_data_o
);
  import ssa_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  op_t              entry_q [QDEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = entry_q[rptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_i && pop_valid_o;

  always_comb begin
    wptr_d = push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/ssa_back.sv
module ssa_back #(
  parameter int SLOTS            = 4096,
  parameter int SECTORS_PER_SLOT = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ssa_pkg::op_t              op_i,
  input  logic                      op_valid_i,
  output logic                      op_pop_o,
  input  logic [ssa_pkg::LIM_W-1:0] limit_i,
  ssa_out_if.source                 rsp_o
);
  import ssa_pkg::*;

  localparam int ROWS   = (SLOTS + WORD_W - 1) / WORD_W;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FS_W   = ROW_W + BIT_W;
  localparam int CMP_W  = (FS_W > LIM_W) ? FS_W : LIM_W;
  localparam int STEP_W = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SECTORS_PER_SLOT - 1);
  localparam logic [SEC_W-1:0]  SPS_C     = SEC_W'(SECTORS_PER_SLOT);

  bstate_e             state_q, state_d;
  op_e                 op_q, op_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [BIT_W-1:0]    bit_q, bit_d;
  logic [LIM_W-1:0]    slot_q, slot_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [SEC_W-1:0]    base_q, base_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [ROWS-1:0]     row_full_q, row_full_d;
  logic [ROWS-1:0]     row_vld_q, row_vld_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [SLOT_W-1:0]   out_slot_q, out_slot_d;
  logic [SEC_W-1:0]    out_sector_q, out_sector_d;
  logic                out_last_q, out_last_d;
  logic                out_load, out_free;

  logic              ram_we, ram_re;
  logic [WORD_W-1:0] ram_wdata, ram_rdata, word;
  logic [ROW_W-1:0]  free_row;
  logic              free_row_found;
  logic [BIT_W-1:0]  zero_bit;
  logic              zero_found;
  logic [CMP_W-1:0]  alloc_slot;
  logic              alloc_ok;
  logic              hit;
  logic [WORD_W-1:0] clr_mask;
  logic [LIM_W-1:0]  base_slot;

  ssa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (row_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (row_q),
    .rdata_o (ram_rdata)
  );

  // lowest row that still has a free bit
  always_comb begin
    free_row       = '0;
    free_row_found = 1'b0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (!row_full_q[i]) begin
        free_row       = ROW_W'(i);
        free_row_found = 1'b1;
      end
    end
  end

  // a row never written reads as all free
  assign word = row_vld_q[row_q] ? ram_rdata : '0;

  always_comb begin
    zero_bit   = '0;
    zero_found = 1'b0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        zero_bit   = BIT_W'(i);
        zero_found = 1'b1;
      end
    end
  end

  assign alloc_slot = CMP_W'({row_q, zero_bit});
  assign alloc_ok   = zero_found && (alloc_slot < CMP_W'(limit_i));
  assign hit        = word[bit_q];
  assign clr_mask   = ~(WORD_W'(1) << bit_q);
  assign base_slot  = (op_q == OP_ALLOC) ? alloc_slot[LIM_W-1:0] : slot_q;
  assign out_free   = !out_valid_q || rsp_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (op_valid_i) begin
          case (op_i.op)
            OP_ALLOC:            state_d = free_row_found ? S_READ : S_SINGLE;
            OP_SWAP_IN, OP_FREE: state_d = S_READ;
            default:             state_d = S_SINGLE;
          endcase
        end
      end
      S_READ:  state_d = S_CHECK;
      S_CHECK: begin
        case (op_q)
          OP_ALLOC:   state_d = alloc_ok ? S_EMIT : S_SINGLE;
          OP_SWAP_IN: state_d = hit ? S_EMIT : S_SINGLE;
          default:    state_d = S_SINGLE;
        endcase
      end
      S_EMIT: begin
        if (out_free && (step_q == STEP_LAST)) begin
          state_d = S_IDLE;
        end
      end
      S_SINGLE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    op_pop_o     = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_wdata    = word;
    out_load     = 1'b0;
    op_d         = op_q;
    row_d        = row_q;
    bit_d        = bit_q;
    slot_d       = slot_q;
    status_d     = status_q;
    base_d       = base_q;
    step_d       = step_q;
    row_full_d   = row_full_q;
    row_vld_d    = row_vld_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_sector_d = out_sector_q;
    out_last_d   = out_last_q;
    case (state_q)
      S_IDLE: begin
        op_pop_o = op_valid_i;
        if (op_valid_i) begin
          op_d     = op_i.op;
          status_d = op_i.status;
          slot_d   = LIM_W'(op_i.slot);
          bit_d    = op_i.slot[BIT_W-1:0];
          row_d    = ROW_W'(op_i.slot >> BIT_W);
          if (op_i.op == OP_ALLOC) begin
            row_d = free_row;
            if (!free_row_found) begin
              status_d = ST_FULL;
              slot_d   = '0;
            end
          end
        end
      end
      S_READ: ram_re = 1'b1;
      S_CHECK: begin
        step_d = '0;
        base_d = SEC_W'(SEC_W'(base_slot) * SPS_C);
        case (op_q)
          OP_ALLOC: begin
            if (alloc_ok) begin
              ram_we    = 1'b1;
              ram_wdata = word | (WORD_W'(1) << zero_bit);
              slot_d    = alloc_slot[LIM_W-1:0];
            end else begin
              status_d = ST_FULL;
              slot_d   = '0;
            end
          end
          OP_SWAP_IN: begin
            if (hit) begin
              ram_we    = 1'b1;
              ram_wdata = word & clr_mask;
            end else begin
              status_d = ST_BAD;
              slot_d   = '0;
            end
          end
          OP_FREE: begin
            ram_we    = 1'b1;
            ram_wdata = word & clr_mask;
          end
          default: ;
        endcase
        if (ram_we) begin
          row_vld_d[row_q]  = 1'b1;
          row_full_d[row_q] = &ram_wdata;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = ST_OK;
          out_slot_d   = SLOT_W'(slot_q);
          out_sector_d = base_q + SEC_W'(step_q);
          out_last_d   = (step_q == STEP_LAST);
          step_d       = step_q + 1'b1;
        end
      end
      S_SINGLE: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = status_q;
          out_slot_d   = SLOT_W'(slot_q);
          out_sector_d = '0;
          out_last_d   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_full_q  <= '0;
      row_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_full_q  <= row_full_d;
      row_vld_q   <= row_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    row_q        <= row_d;
    bit_q        <= bit_d;
    slot_q       <= slot_d;
    status_q     <= status_d;
    base_q       <= base_d;
    step_q       <= step_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_sector_q <= out_sector_d;
    out_last_q   <= out_last_d;
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.slot_number    = out_slot_q;
  assign rsp_o.sector_address = out_sector_q;
  assign rsp_o.last           = out_last_q;

  a_we_in_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CHECK))
    else $error("bitmap written outside the check cycle");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop_o |-> (state_q == S_IDLE) && op_valid_i)
    else $error("queue popped while busy or empty");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (step_q <= STEP_LAST))
    else $error("sector step out of range");

  a_alloc_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && op_q == OP_ALLOC && ram_we)
      |=> (state_q == S_EMIT) && row_vld_q[$past(row_q)])
    else $error("allocation did not mark its row");

  a_err_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != ST_OK) |-> (out_sector_q == '0) && out_last_q)
    else $error("error result carries a sector");

endmodule
